// ===== rtl/tpr_pkg.sv =====
// Shared types and constants for the thin-plate RBF evaluator.
// No dependencies.
package tpr_pkg;

  localparam int DW = 50;
  localparam int XW = 31;
  localparam int FW = 32;
  localparam int EW = 7;
  localparam int TW = 64;
  localparam int VW = 48;
  localparam int CW = 7;

  localparam logic [23:0] LN2_HALF_Q24 = 24'd5814540;
  localparam logic [VW-1:0] VAL_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [VW-1:0] VAL_MIN = 48'h8000_0000_0000;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef struct packed {
    logic                 vld;
    logic                 last;
    logic                 zero;
    logic signed [EW-1:0] e;
    logic [DW-1:0]        d;
    logic signed [31:0]   w;
  } tpr_side_t;

  typedef struct packed {
    logic                 vld;
    logic                 last;
    logic signed [TW-1:0] term;
  } tpr_term_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } tpr_state_t;

endpackage

// ===== rtl/tpr_log_cell.sv =====
// One log2 fraction cell: square the Q1.30 mantissa and emit one bit.
// Depends on tpr_pkg.
module tpr_log_cell import tpr_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  tpr_side_t       side_i,
  input  logic [XW-1:0]   x_i,
  input  logic [FW-1:0]   frac_i,
  output tpr_side_t       side_o,
  output logic [XW-1:0]   x_o,
  output logic [FW-1:0]   frac_o
);

  tpr_side_t         side_r;
  logic [XW-1:0]     x_r, x_nxt;
  logic [FW-1:0]     frac_r, frac_nxt;
  logic [2*XW-1:0]   sq;
  logic [31:0]       y;

  always_comb begin
    sq       = x_i * x_i;
    y        = sq[61:30];
    x_nxt    = y[31] ? y[31:1] : y[30:0];
    frac_nxt = {frac_i[FW-2:0], y[31]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.vld <= 1'b0;
    end else begin
      side_r <= side_i;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    frac_r <= frac_nxt;
  end

  assign side_o = side_r;
  assign x_o    = x_r;
  assign frac_o = frac_r;

endmodule

// ===== rtl/tpr_term_unit.sv =====
// Term pipeline: 0.5*ln(d) from log2, then d*h and w*d*h in Q.16.
// Depends on tpr_pkg.
module tpr_term_unit import tpr_pkg::*; #(
  parameter int LOG_ITERATIONS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  tpr_side_t     side_i,
  input  logic [FW-1:0] frac_i,
  output tpr_term_t     term_o
);

  tpr_side_t            s1_r, s2_r, s3_r, s4_r;
  logic signed [30:0]   h1_r, h1_nxt;
  logic signed [57:0]   a2_r, a2_nxt;
  logic signed [55:0]   b2_r, b2_nxt;
  logic signed [50:0]   dh3_r, dh3_nxt;
  logic signed [66:0]   p1_r, p1_nxt;
  logic signed [48:0]   p2_r, p2_nxt;
  tpr_term_t            t5_r, t5_nxt;

  logic [FW-1:0]        fsh;
  logic signed [62:0]   hp;
  logic signed [58:0]   sum3;
  logic signed [55:0]   bs;
  logic signed [48:0]   p2s;

  always_comb begin
    fsh    = frac_i << (FW - LOG_ITERATIONS);
    hp     = $signed({side_i.e, fsh}) * $signed({1'b0, LN2_HALF_Q24});
    h1_nxt = hp[62:32];

    a2_nxt = $signed({1'b0, s1_r.d[49:24]}) * h1_r;
    b2_nxt = $signed({1'b0, s1_r.d[23:0]}) * h1_r;

    bs      = b2_r >>> 24;
    sum3    = 59'(a2_r) + 59'(bs);
    dh3_nxt = sum3[58:8];

    p1_nxt = s3_r.w * $signed(dh3_r[50:16]);
    p2_nxt = s3_r.w * $signed({1'b0, dh3_r[15:0]});

    p2s          = p2_r >>> 16;
    t5_nxt.vld   = s4_r.vld;
    t5_nxt.last  = s4_r.last;
    t5_nxt.term  = s4_r.zero ? '0 : (p1_r[63:0] + 64'(p2s));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
      s2_r.vld <= 1'b0;
      s3_r.vld <= 1'b0;
      s4_r.vld <= 1'b0;
      t5_r.vld <= 1'b0;
    end else begin
      s1_r <= side_i;
      s2_r <= s1_r;
      s3_r <= s2_r;
      s4_r <= s3_r;
      t5_r <= t5_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h1_r  <= h1_nxt;
    a2_r  <= a2_nxt;
    b2_r  <= b2_nxt;
    dh3_r <= dh3_nxt;
    p1_r  <= p1_nxt;
    p2_r  <= p2_nxt;
  end

  assign term_o = t5_r;

endmodule

// ===== rtl/thin_plate_rbf_evaluate.sv =====
// Thin-plate RBF evaluator: center table, distance front end, log2 cell row,
// term pipeline and accumulator. Depends on tpr_pkg, tpr_log_cell, tpr_term_unit.
// Load word: written into the center table. Query word: a result once n centers
// have run through the pipeline (directly with no centers in use),
// n = min(centers_in_use, MAX_CENTERS); one center enters the cell row per cycle.
// Reset (synchronous, rst_n low): idle, no result pending, centers_in_use = 1;
// the center table is not cleared.
module thin_plate_rbf_evaluate import tpr_pkg::*; #(
  parameter int MAX_CENTERS    = 64,
  parameter int LOG_ITERATIONS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_opcode,
  input  logic [5:0]          in_slot,
  input  logic signed [23:0]  in_coord_x,
  input  logic signed [23:0]  in_coord_y,
  input  logic signed [31:0]  in_weight_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [VW-1:0] out_value,
  output logic                out_saturated,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int AW    = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
  localparam int ACC_W = TW + $clog2(MAX_CENTERS) + 1;

  tpr_state_t state_r, state_nxt;
  logic [CW-1:0] cfg_r;
  logic [AW-1:0] cnt_r, n_last_r;
  logic signed [23:0] qx_r, qy_r;

  logic [79:0] mem [MAX_CENTERS];
  logic [79:0] mem_q_r;
  logic        f0_vld_r, f0_last_r;
  logic        f1_vld_r, f1_last_r, f2_vld_r, f2_last_r, f3_vld_r, f3_last_r;
  logic signed [24:0] dx1_r, dy1_r;
  logic signed [31:0] w1_r, w2_r, w3_r;
  logic signed [49:0] dx2_r, dy2_r;
  logic [DW-1:0] d3_r;
  tpr_side_t     f4_r, f4_nxt;
  logic [XW-1:0] x4_r, x4_nxt;

  tpr_side_t     side_c [LOG_ITERATIONS+1];
  logic [XW-1:0] x_c    [LOG_ITERATIONS+1];
  logic [FW-1:0] f_c    [LOG_ITERATIONS+1];
  tpr_term_t     sum_t;

  logic signed [ACC_W-1:0] acc_r;
  logic                    out_valid_r;
  logic [VW-1:0]           out_value_r;
  logic                    out_sat_r;

  logic        in_acc, q_start, ld_en, issue, done_load, last_issue, cfg_wr;
  logic [31:0] slot_w, n_eff, n_last_w;
  logic [5:0]  p4;
  logic [DW-1:0] nrm;
  logic [ACC_W-VW:0] upper;
  logic        ovf;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {25'd0, cfg_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= 7'd1;
    end else if (cfg_wr) begin
      cfg_r <= pwdata[CW-1:0];
    end
  end

  always_comb begin
    slot_w     = 32'(in_slot);
    n_eff      = (32'(cfg_r) > 32'(MAX_CENTERS)) ? 32'(MAX_CENTERS) : 32'(cfg_r);
    n_last_w   = n_eff - 32'd1;
    in_acc     = in_valid & in_ready;
    q_start    = in_acc & (in_opcode == OP_EVAL);
    ld_en      = in_acc & (in_opcode == OP_LOAD) & (slot_w < 32'(MAX_CENTERS));
    last_issue = (cnt_r == n_last_r);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (q_start) state_nxt = (cfg_r == '0) ? ST_DONE : ST_RUN;
      ST_RUN:   if (last_issue) state_nxt = ST_DRAIN;
      ST_DRAIN: if (sum_t.vld && sum_t.last) state_nxt = ST_DONE;
      ST_DONE:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    issue     = 1'b0;
    done_load = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ready  = 1'b1;
      ST_RUN:   issue     = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  done_load = !out_valid_r || out_ready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (q_start) cnt_r <= '0;
      else if (issue) cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_start) begin
      qx_r     <= in_coord_x;
      qy_r     <= in_coord_y;
      n_last_r <= n_last_w[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld_en) mem[slot_w[AW-1:0]] <= {in_weight_in, in_coord_y, in_coord_x};
    mem_q_r <= mem[cnt_r];
  end

  always_comb begin
    p4 = '0;
    for (int i = 0; i < DW; i++) begin
      if (d3_r[i]) p4 = 6'(i);
    end
    nrm         = d3_r << (6'(DW - 1) - p4);
    x4_nxt      = nrm[DW-1:DW-XW];
    f4_nxt.vld  = f3_vld_r;
    f4_nxt.last = f3_last_r;
    f4_nxt.zero = (d3_r == '0);
    f4_nxt.e    = $signed({1'b0, p4}) - 7'sd24;
    f4_nxt.d    = d3_r;
    f4_nxt.w    = w3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_vld_r <= 1'b0;
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
      f3_vld_r <= 1'b0;
      f4_r.vld <= 1'b0;
    end else begin
      f0_vld_r <= issue;
      f1_vld_r <= f0_vld_r;
      f2_vld_r <= f1_vld_r;
      f3_vld_r <= f2_vld_r;
      f4_r     <= f4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    f0_last_r <= last_issue;
    f1_last_r <= f0_last_r;
    f2_last_r <= f1_last_r;
    f3_last_r <= f2_last_r;
    dx1_r     <= 25'(qx_r) - 25'($signed(mem_q_r[23:0]));
    dy1_r     <= 25'(qy_r) - 25'($signed(mem_q_r[47:24]));
    w1_r      <= mem_q_r[79:48];
    dx2_r     <= dx1_r * dx1_r;
    dy2_r     <= dy1_r * dy1_r;
    w2_r      <= w1_r;
    d3_r      <= dx2_r + dy2_r;
    w3_r      <= w2_r;
    x4_r      <= x4_nxt;
  end

  assign side_c[0] = f4_r;
  assign x_c[0]    = x4_r;
  assign f_c[0]    = '0;

  for (genvar g = 0; g < LOG_ITERATIONS; g++) begin : g_cell
    tpr_log_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .side_i (side_c[g]),
      .x_i    (x_c[g]),
      .frac_i (f_c[g]),
      .side_o (side_c[g+1]),
      .x_o    (x_c[g+1]),
      .frac_o (f_c[g+1])
    );
  end

  tpr_term_unit #(
    .LOG_ITERATIONS (LOG_ITERATIONS)
  ) u_term (
    .clk    (clk),
    .rst_n  (rst_n),
    .side_i (side_c[LOG_ITERATIONS]),
    .frac_i (f_c[LOG_ITERATIONS]),
    .term_o (sum_t)
  );

  always_ff @(posedge clk) begin
    if (q_start) acc_r <= '0;
    else if (sum_t.vld) acc_r <= acc_r + ACC_W'(sum_t.term);
  end

  always_comb begin
    upper = acc_r[ACC_W-1:VW-1];
    ovf   = !(&upper) && (|upper);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_load) begin
      out_value_r <= ovf ? (acc_r[ACC_W-1] ? VAL_MIN : VAL_MAX) : acc_r[VW-1:0];
      out_sat_r   <= ovf;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_saturated = out_sat_r;

  a_term_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    sum_t.vld |-> (state_r == ST_RUN || state_r == ST_DRAIN))
    else $error("term word outside a query");

  a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> !sum_t.vld && !f0_vld_r)
    else $error("result taken with words in flight");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (cnt_r <= n_last_r))
    else $error("issue counter past last center");

endmodule
